@@ hw/rtl/tsbc_pkg.sv @@
// Package for the timed stepper blind controller.
// Holds the item structs, drive mode codes, register indexes and the coil table.
// No dependencies.
package tsbc_pkg;

  // Width of the millisecond time base; differences wrap at this width
  localparam int TimeBits = 32;

  typedef logic [TimeBits-1:0] time_ms_t;

  // Drive modes
  typedef logic [2:0] mode_t;
  localparam mode_t ModeOpen      = 3'd0;
  localparam mode_t ModeClose     = 3'd1;
  localparam mode_t ModeAutoOpen  = 3'd2;
  localparam mode_t ModeAutoClose = 3'd3;
  localparam mode_t ModeStop      = 3'd4;

  // Configuration register indexes
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t RegCodeClose   = 2'd0;
  localparam cfg_index_t RegCodeOpen    = 2'd1;
  localparam cfg_index_t RegCodeCal     = 2'd2;
  localparam cfg_index_t RegFlashPeriod = 2'd3;

  // Register reset values
  localparam logic [31:0] CodeCloseReset   = 32'h02FD_807F;
  localparam logic [31:0] CodeOpenReset    = 32'h02FD_40BF;
  localparam logic [31:0] CodeCalReset     = 32'h02FD_C03F;
  localparam logic [15:0] FlashPeriodReset = 16'd125;

  // Input item: one control tick
  typedef struct packed {
    logic        code_valid;
    logic [31:0] remote_code;
    logic        calibrate_level;
    logic        close_level;
    logic        open_level;
    logic [31:0] now_ms;
  } tick_t;

  // Result item
  typedef struct packed {
    logic [11:0] coil_pattern;
    logic        led_on;
    mode_t       drive_mode;
  } step_t;

  // Full-step coil patterns for all three motors, by phase
  function automatic logic [11:0] coil_pattern(input logic [1:0] phase);
    logic [11:0] pat;
    case (phase)
      2'd0:    pat = 12'd3276;
      2'd1:    pat = 12'd1638;
      2'd2:    pat = 12'd819;
      default: pat = 12'd2457;
    endcase
    return pat;
  endfunction

endpackage

@@ hw/rtl/timed_stepper_blind_controller.sv @@
// Timed stepper blind controller, top level.
// Input register, one pass of tick logic, result register. Uses tsbc_pkg.
//
//   channel  direction  handshake                     payload
//   tick     in         tick_valid / tick_stall       tick_item (tsbc_pkg::tick_t)
//   step     out        step_valid / step_stall       step_item (tsbc_pkg::step_t)
//   cfg      in         cfg_we                        cfg_index, cfg_data
//
// An accepted item is held in the input register and passes the tick logic
// into the result register once that register is empty or not stalled. One
// item is accepted per cycle while tick is not stalled; the tick logic is a
// single pass between the two registers. A stalled result holds the result
// register and, once the input register is also full, stalls tick.
// Reset (rst, synchronous) clears both valid flags, all controller state
// and restores the configuration registers.
module timed_stepper_blind_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick_valid,
  output logic                  tick_stall,
  input  tsbc_pkg::tick_t       tick_item,
  output logic                  step_valid,
  input  logic                  step_stall,
  output tsbc_pkg::step_t       step_item,
  input  logic                  cfg_we,
  input  tsbc_pkg::cfg_index_t  cfg_index,
  input  logic [31:0]           cfg_data
);

  // Configuration
  logic [31:0] code_close;
  logic [31:0] code_open;
  logic [31:0] code_calibrate;
  logic [15:0] flash_period_ms;

  // Pipeline
  logic            in_vld;
  tsbc_pkg::tick_t in_q;
  logic            advance;

  // Controller state
  tsbc_pkg::mode_t    mode_reg, mode_reg_next;
  logic               button_calibrating, button_calibrating_next;
  logic               remote_calibrating, remote_calibrating_next;
  logic               timing_active, timing_active_next;
  logic               auto_active, auto_active_next;
  tsbc_pkg::time_ms_t timing_start, timing_start_next;
  tsbc_pkg::time_ms_t auto_start, auto_start_next;
  tsbc_pkg::time_ms_t travel_time, travel_time_next;
  tsbc_pkg::time_ms_t blink_mark, blink_mark_next;
  logic               blink_armed, blink_armed_next;
  logic               led_reg, led_reg_next;
  logic [1:0]         phase_index, phase_index_next;
  logic [2:0]         prev_levels;
  logic [11:0]        pat_next;

  assign advance    = in_vld && (!step_valid || !step_stall);
  assign tick_stall = in_vld && !advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      code_close      <= tsbc_pkg::CodeCloseReset;
      code_open       <= tsbc_pkg::CodeOpenReset;
      code_calibrate  <= tsbc_pkg::CodeCalReset;
      flash_period_ms <= tsbc_pkg::FlashPeriodReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsbc_pkg::RegCodeClose:   code_close      <= cfg_data;
        tsbc_pkg::RegCodeOpen:    code_open       <= cfg_data;
        tsbc_pkg::RegCodeCal:     code_calibrate  <= cfg_data;
        tsbc_pkg::RegFlashPeriod: flash_period_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!tick_stall) begin
      in_vld <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!tick_stall && tick_valid) begin
      in_q <= tick_item;
    end
  end

  // Tick logic: remote, calibrate button, LED, close/open buttons, drive mode
  always_comb begin
    tsbc_pkg::time_ms_t now;
    logic prev_cal, prev_close, prev_open, fwd;
    now      = tsbc_pkg::time_ms_t'(in_q.now_ms);
    prev_cal   = prev_levels[0];
    prev_close = prev_levels[1];
    prev_open  = prev_levels[2];
    fwd        = 1'b0;

    mode_reg_next           = mode_reg;
    button_calibrating_next = button_calibrating;
    remote_calibrating_next = remote_calibrating;
    timing_active_next      = timing_active;
    auto_active_next        = auto_active;
    timing_start_next       = timing_start;
    auto_start_next         = auto_start;
    travel_time_next        = travel_time;
    blink_mark_next         = blink_mark;
    blink_armed_next        = blink_armed;
    led_reg_next            = led_reg;
    phase_index_next        = phase_index;
    pat_next                = '0;

    // remote decoding
    if (in_q.code_valid) begin
      if (!remote_calibrating) begin
        if (in_q.remote_code == code_open) begin
          mode_reg_next = tsbc_pkg::ModeAutoOpen;
        end else if (in_q.remote_code == code_close) begin
          mode_reg_next = tsbc_pkg::ModeAutoClose;
        end else if (in_q.remote_code == code_calibrate) begin
          remote_calibrating_next = 1'b1;
        end
      end else begin
        if (in_q.remote_code == code_calibrate) begin
          remote_calibrating_next = 1'b0;
        end else if (in_q.remote_code == code_close) begin
          mode_reg_next = (mode_reg != tsbc_pkg::ModeClose) ? tsbc_pkg::ModeClose
                                                            : tsbc_pkg::ModeStop;
        end else if (in_q.remote_code == code_open) begin
          if (mode_reg != tsbc_pkg::ModeOpen) begin
            timing_active_next = 1'b1;
            timing_start_next  = now;
            mode_reg_next      = tsbc_pkg::ModeOpen;
          end else begin
            travel_time_next        = now - timing_start;
            mode_reg_next           = tsbc_pkg::ModeStop;
            timing_active_next      = 1'b0;
            remote_calibrating_next = 1'b0;
          end
        end
      end
    end

    // calibrate button toggles on a rising level
    if (in_q.calibrate_level && !prev_cal) begin
      button_calibrating_next = !button_calibrating;
    end

    // LED blinking while either calibration is on
    if (button_calibrating_next || remote_calibrating_next) begin
      if (!blink_armed) begin
        blink_armed_next = 1'b1;
        blink_mark_next  = now;
      end else if ((now - blink_mark) > tsbc_pkg::time_ms_t'(flash_period_ms)) begin
        led_reg_next     = !led_reg;
        blink_armed_next = 1'b0;
        blink_mark_next  = '0;
      end
    end else begin
      led_reg_next = 1'b0;
    end

    // close button
    if (in_q.close_level != prev_close) begin
      if (button_calibrating_next) begin
        mode_reg_next = in_q.close_level ? tsbc_pkg::ModeClose : tsbc_pkg::ModeStop;
      end else if (in_q.close_level && mode_reg_next != tsbc_pkg::ModeAutoClose) begin
        mode_reg_next = tsbc_pkg::ModeAutoClose;
      end
    end

    // open button: timed manual open while button calibration is on, else auto open
    if (button_calibrating_next) begin
      if (in_q.open_level) begin
        if (!timing_active_next) begin
          timing_active_next = 1'b1;
          timing_start_next  = now;
        end
        mode_reg_next = tsbc_pkg::ModeOpen;
      end else if (timing_active_next) begin
        travel_time_next        = now - timing_start_next;
        mode_reg_next           = tsbc_pkg::ModeStop;
        timing_active_next      = 1'b0;
        button_calibrating_next = 1'b0;
      end
    end else if (in_q.open_level && !prev_open &&
                 mode_reg_next != tsbc_pkg::ModeAutoOpen) begin
      mode_reg_next = tsbc_pkg::ModeAutoOpen;
    end

    // drive mode processing
    if (mode_reg_next == tsbc_pkg::ModeAutoOpen || mode_reg_next == tsbc_pkg::ModeAutoClose) begin
      fwd = (mode_reg_next == tsbc_pkg::ModeAutoOpen);
      if (!auto_active) begin
        auto_active_next = 1'b1;
        auto_start_next  = now;
        pat_next         = tsbc_pkg::coil_pattern(phase_index);
        phase_index_next = fwd ? phase_index + 2'd1 : phase_index - 2'd1;
      end else if ((now - auto_start) >= travel_time_next) begin
        auto_active_next = 1'b0;
        auto_start_next  = '0;
        mode_reg_next    = tsbc_pkg::ModeStop;
      end else begin
        pat_next         = tsbc_pkg::coil_pattern(phase_index);
        phase_index_next = fwd ? phase_index + 2'd1 : phase_index - 2'd1;
      end
    end else if (mode_reg_next == tsbc_pkg::ModeOpen) begin
      pat_next         = tsbc_pkg::coil_pattern(phase_index);
      phase_index_next = phase_index + 2'd1;
    end else if (mode_reg_next == tsbc_pkg::ModeClose) begin
      pat_next         = tsbc_pkg::coil_pattern(phase_index);
      phase_index_next = phase_index - 2'd1;
    end else begin
      mode_reg_next = tsbc_pkg::ModeStop;
    end
  end

  // State update, one item per advance
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg           <= tsbc_pkg::ModeStop;
      button_calibrating <= 1'b0;
      remote_calibrating <= 1'b0;
      timing_active      <= 1'b0;
      auto_active        <= 1'b0;
      timing_start       <= '0;
      auto_start         <= '0;
      travel_time        <= '0;
      blink_mark         <= '0;
      blink_armed        <= 1'b0;
      led_reg            <= 1'b0;
      phase_index        <= '0;
      prev_levels        <= '0;
    end else if (advance) begin
      mode_reg           <= mode_reg_next;
      button_calibrating <= button_calibrating_next;
      remote_calibrating <= remote_calibrating_next;
      timing_active      <= timing_active_next;
      auto_active        <= auto_active_next;
      timing_start       <= timing_start_next;
      auto_start         <= auto_start_next;
      travel_time        <= travel_time_next;
      blink_mark         <= blink_mark_next;
      blink_armed        <= blink_armed_next;
      led_reg            <= led_reg_next;
      phase_index        <= phase_index_next;
      prev_levels        <= {in_q.open_level, in_q.close_level, in_q.calibrate_level};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
    end else if (advance) begin
      step_valid <= 1'b1;
    end else if (!step_stall) begin
      step_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      step_item.coil_pattern <= pat_next;
      step_item.led_on       <= led_reg_next;
      step_item.drive_mode   <= mode_reg_next;
    end
  end

  // Checks
  a_stop_no_coils: assert property (@(posedge clk) disable iff (rst)
    step_valid && step_item.drive_mode == tsbc_pkg::ModeStop |-> step_item.coil_pattern == '0)
    else $error("coil pattern driven in stop mode");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> in_vld && step_valid && step_stall)
    else $error("tick stalled with room downstream");

  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> step_valid)
    else $error("advanced item produced no result");

  a_timing_needs_cal: assert property (@(posedge clk) disable iff (rst)
    advance && timing_active_next |-> button_calibrating_next || remote_calibrating_next ||
      timing_active)
    else $error("travel timing started outside calibration");

endmodule
